>>> hdl/ipv6_five_tuple_mask_classifier_unit_defines.svh
// assertion macros for the ipv6 five-tuple classifier
`ifndef IPV6_FIVE_TUPLE_MASK_CLASSIFIER_UNIT_DEFINES_SVH
`define IPV6_FIVE_TUPLE_MASK_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define IFTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IFTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/iftc_pkg.sv
// shared types and constants of the ipv6 five-tuple classifier
`default_nettype none
package iftc_pkg;
  localparam int RULES      = 1024;
  localparam int CELLS      = 8;
  localparam int LOC_RULES  = RULES / CELLS;
  localparam int WORDS      = 5;
  localparam int MEM_DEPTH  = LOC_RULES * WORDS;
  localparam int RULE_W     = $clog2(RULES);
  localparam int CELL_W     = $clog2(CELLS);
  localparam int LOC_W      = $clog2(LOC_RULES);
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int WSEL_W     = 3;
  localparam int IDX_OUT_W  = 11;
  localparam int MERGE_CYC  = CELLS + 2;
  localparam int MCNT_W     = $clog2(MERGE_CYC + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_KEY   = 1'b1;
  localparam logic [WSEL_W-1:0] WORD_LAST = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  word_select;
    logic [9:0]  entry_index;
    logic [63:0] word_value;
    logic [63:0] word_mask;
    logic [31:0] packet_tag;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] matched_index;
    logic [31:0]          tag_out;
  } out_t;

  // rule word write toward one cell
  typedef struct packed {
    logic              en;
    logic [LOC_W-1:0]  loc;
    logic [WSEL_W-1:0] word;
    logic [63:0]       mask;
    logic [63:0]       mval;
  } wr_t;

  // compare stage control, aligned with registered read data
  typedef struct packed {
    logic              en;
    logic [WSEL_W-1:0] word;
    logic [LOC_W-1:0]  loc;
    logic [63:0]       key;
  } cmp_t;

  // partial result handed along the chain
  typedef struct packed {
    logic              hit;
    logic [RULE_W-1:0] idx;
  } hand_t;
endpackage
`default_nettype wire

>>> hdl/iftc_cell.sv
// one classifier cell: a slice of the rule table and its first-match tracker
`default_nettype none
module iftc_cell
  import iftc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CELL_W-1:0] cell_id,
  input  wire wr_t               wr,
  input  wire logic              clear,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire cmp_t              cmp,
  input  wire hand_t             hand_in,
  output hand_t                  hand_out
);
  logic [127:0]         mem [MEM_DEPTH];
  logic [127:0]         rd_q;
  logic [LOC_RULES-1:0] valid;
  logic                 ok_acc;
  logic                 found;
  logic [LOC_W-1:0]     floc;
  logic [ADDR_W-1:0]    waddr;
  logic                 ok_now;

  function automatic logic [ADDR_W-3:0] loc_ext(input logic [LOC_W-1:0] l);
    loc_ext = (ADDR_W-2)'(l);
  endfunction

  // word address within the slice is loc*5 + word
  assign waddr = ADDR_W'({loc_ext(wr.loc), 2'b00}) + ADDR_W'(wr.loc) + ADDR_W'(wr.word);

  // rule word storage
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= {wr.mask, wr.mval};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // masked compare of the current word
  assign ok_now = ((cmp.word == '0) ? 1'b1 : ok_acc) &&
                  ((cmp.key & rd_q[127:64]) == rd_q[63:0]);

  // valid bits and first match of this slice
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      found <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.loc] <= 1'b1;
      end
      if (clear) begin
        found <= 1'b0;
      end else if (cmp.en && cmp.word == WORD_LAST && valid[cmp.loc] && ok_now && !found) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp.en) begin
      ok_acc <= ok_now;
    end
    if (cmp.en && cmp.word == WORD_LAST && !found) begin
      floc <= cmp.loc;
    end
  end

  // hand the lower-numbered winner toward cell zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hand_out <= '0;
    end else begin
      hand_out.hit <= found | hand_in.hit;
      hand_out.idx <= found ? {cell_id, floc} : hand_in.idx;
    end
  end
endmodule
`default_nettype wire

>>> hdl/ipv6_five_tuple_mask_classifier_unit.sv
// top level: sweep sequencer, key registers and a chain of classifier cells
//
//  channel | signals                        | direction
//  in      | in_valid, in_ready, in_data    | rule writes, key loads, lookups
//  out     | out_valid, out_ready, out_data | one result per lookup
//
// a lookup sweeps every cell's rule memory one word per cycle;
//   the partial results then pass along the cell chain to cell zero.
// the single read port of each cell memory sets that pace.
// reset clears valid bits, key words and control; rule memories need no clearing.
// a finished result waits in the output register; a new request is taken meanwhile.
`default_nettype none
`include "ipv6_five_tuple_mask_classifier_unit_defines.svh"
module ipv6_five_tuple_mask_classifier_unit
  import iftc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_MERGE = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [63:0]       key_words [4];
  logic [63:0]       last_word;
  logic [31:0]       tag;
  logic [ADDR_W-1:0] rd_addr;
  logic [WSEL_W-1:0] w_cnt;
  logic [LOC_W-1:0]  l_cnt;
  logic [MCNT_W-1:0] m_cnt;
  cmp_t              cmp;
  logic              acc, do_write, do_key, do_look, issue_last, merge_done, out_free;
  wr_t               wr [CELLS];
  hand_t             hand [CELLS+1];

  assign in_ready   = (state == S_IDLE);
  assign acc        = in_valid && in_ready && (in_data.word_select <= WORD_LAST);
  assign do_write   = acc && in_data.opcode == OP_WRITE &&
                      ({1'b0, in_data.entry_index} < (RULE_W+1)'(RULES));
  assign do_key     = acc && in_data.opcode == OP_KEY && in_data.word_select != WORD_LAST;
  assign do_look    = acc && in_data.opcode == OP_KEY && in_data.word_select == WORD_LAST;
  assign issue_last = (state == S_SWEEP) && rd_addr == ADDR_W'(MEM_DEPTH - 1);
  assign merge_done = (state == S_MERGE) && m_cnt == MCNT_W'(MERGE_CYC);
  assign out_free   = !out_valid || out_ready;

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (do_look) state_next = S_SWEEP;
      S_SWEEP: if (issue_last) state_next = S_MERGE;
      S_MERGE: if (merge_done && out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_words[i] <= '0;
    end else if (do_key) begin
      key_words[in_data.word_select[1:0]] <= in_data.word_value;
    end
  end

  always_ff @(posedge clk) begin
    if (do_look) begin
      last_word <= in_data.word_value;
      tag       <= in_data.packet_tag;
    end
  end

  // read address sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      w_cnt   <= '0;
      l_cnt   <= '0;
      m_cnt   <= '0;
    end else begin
      if (do_look) begin
        rd_addr <= '0;
        w_cnt   <= '0;
        l_cnt   <= '0;
      end else if (state == S_SWEEP) begin
        rd_addr <= rd_addr + 1'b1;
        if (w_cnt == WORD_LAST) begin
          w_cnt <= '0;
          l_cnt <= l_cnt + 1'b1;
        end else begin
          w_cnt <= w_cnt + 1'b1;
        end
      end
      if (state == S_SWEEP) begin
        m_cnt <= '0;
      end else if (state == S_MERGE && !merge_done) begin
        m_cnt <= m_cnt + 1'b1;
      end
    end
  end

  // compare stage control, registered in step with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp.en <= 1'b0;
    end else begin
      cmp.en <= (state == S_SWEEP);
    end
    cmp.word <= w_cnt;
    cmp.loc  <= l_cnt;
    cmp.key  <= (w_cnt == WORD_LAST) ? last_word : key_words[w_cnt[1:0]];
  end

  // chain of cells, results move toward cell zero
  assign hand[CELLS] = '0;
  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    always_comb begin
      wr[c].en   = do_write && in_data.entry_index[RULE_W-1 -: CELL_W] == CELL_W'(c);
      wr[c].loc  = in_data.entry_index[LOC_W-1:0];
      wr[c].word = in_data.word_select;
      wr[c].mask = in_data.word_mask;
      wr[c].mval = in_data.word_value & in_data.word_mask;
    end
    iftc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (CELL_W'(c)),
      .wr       (wr[c]),
      .clear    (do_look),
      .rd_en    (state == S_SWEEP),
      .rd_addr  (rd_addr),
      .cmp      (cmp),
      .hand_in  (hand[c+1]),
      .hand_out (hand[c])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (merge_done && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_done && out_free) begin
      out_data.hit           <= hand[0].hit;
      out_data.matched_index <= hand[0].hit ? IDX_OUT_W'(hand[0].idx) : IDX_OUT_W'(RULES);
      out_data.tag_out       <= tag;
    end
  end

  `IFTC_ASSERT_NOW(a_miss_index, out_valid, out_data.hit || out_data.matched_index == IDX_OUT_W'(RULES), "miss must report RULES")
  `IFTC_ASSERT_NEXT(a_look_sweep, do_look, state == S_SWEEP && rd_addr == '0, "lookup must start a sweep")
  `IFTC_ASSERT_NEXT(a_sweep_end, issue_last, state == S_MERGE && cmp.en, "sweep must end in merge")
endmodule
`default_nettype wire
